>>> design/fpml_pkg.sv
// Shared types, constants and the binary32 multiply helpers for the fp multiply unit.
`timescale 1ns / 1ps
`default_nettype none
package fpml_pkg;
  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam logic REQ_ISSUE = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_MUL,
    ST_RND
  } state_t;

  // Operand classification and normalized significand/exponent.
  typedef struct packed {
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [23:0] mant;
    logic signed [9:0] expo;
  } fop_t;

  function automatic logic [4:0] lzc23(input logic [22:0] m);
    logic [4:0] n;
    logic       hit;
    n = 5'd0;
    hit = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!hit && m[i]) begin
        hit = 1'b1;
      end else if (!hit) begin
        n = n + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic fop_t unpack(input logic [31:0] x);
    fop_t        o;
    logic [4:0]  lz;
    o.is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    o.is_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    o.is_zero = (x[30:23] == 8'd0) && (x[22:0] == 23'd0);
    lz = lzc23(x[22:0]);
    if (x[30:23] == 8'd0) begin
      o.mant = {1'b0, x[22:0]} << (lz + 5'd1);
      o.expo = 10'sd1 - $signed({5'd0, lz}) - 10'sd1;
    end else begin
      o.mant = {1'b1, x[22:0]};
      o.expo = $signed({2'b00, x[30:23]});
    end
    return o;
  endfunction
endpackage
`default_nettype wire

>>> design/fpml_round.sv
// Normalize, underflow-shift and round a registered 48-bit significand product.
`timescale 1ns / 1ps
`default_nettype none
module fpml_round (
  input  wire logic              sign,
  input  wire logic [47:0]       prod,
  input  wire logic signed [10:0] expo_sum,
  output logic [31:0]            result
);
  import fpml_pkg::*;
  logic [47:0]        p;
  logic signed [10:0] e;
  logic [10:0]        sh;
  logic [47:0]        ps;
  logic [47:0]        lost_mask;
  logic [23:0]        m;
  logic [23:0]        rem;
  logic [31:0]        bits;
  logic [24:0]        mr;

  always_comb begin
    if (prod[47]) begin
      p = prod;
      e = expo_sum + 11'sd1;
    end else begin
      p = prod << 1;
      e = expo_sum;
    end
    ps = p;
    sh = 11'd0;
    lost_mask = '0;
    if (e < 11'sd1) begin
      sh = 11'(11'sd1 - e);
      if (sh >= 11'd48) begin
        ps = {47'd0, (p != 48'd0)};
      end else begin
        lost_mask = (48'd1 << sh[5:0]) - 48'd1;
        ps = (p >> sh[5:0]) | {47'd0, ((p & lost_mask) != 48'd0)};
      end
    end
    m = ps[47:24];
    rem = ps[23:0];
    mr = {1'b0, m};
    if (rem > 24'h800000 || (rem == 24'h800000 && m[0])) begin
      mr = mr + 25'd1;
    end
    bits = '0;
    result = {sign, 31'd0};
    if (e >= 11'sd255) begin
      result = {sign, 31'h7F800000};
    end else begin
      bits = {(e < 11'sd1) ? 9'd0 : 9'(e - 11'sd1), 23'd0} + {7'd0, mr};
      if (bits >= 32'h7F800000) begin
        result = {sign, 31'h7F800000};
      end else begin
        result = {sign, bits[30:0]};
      end
    end
  end
endmodule
`default_nettype wire

>>> design/fp_multiply_latency_unit.sv
// Top level of the slot-based binary32 multiply unit with configurable latency.
`timescale 1ns / 1ps
`default_nettype none
// An item is taken at a clock edge with start high and busy low. An issue (in_req_type 0)
// looks for a slot holding the same tag, else the lowest free slot, and loads it with the
// factors and a countdown from the latency register; with no slot it gives one rejection
// result. A tick (in_req_type 1) counts every busy slot down and delivers the slots that
// reach zero in ascending tag order. Every item first walks the slot memory one entry a
// cycle through its registered read. A tick then takes each finishing slot through pick
// and read, multiply and round, as one 24x24 multiplier serves them in turn. Each result
// sits on the out_ ports for exactly one cycle with out_valid high and cannot be stalled
// by the receiver. Results leave through an output register, in the cycle after the step
// that makes them, so busy is already low while the final result of an item is shown and
// the next start may be taken in that cycle. Write the latency register only while the
// unit is idle.
module fp_multiply_latency_unit #(
  parameter int SLOTS = 8,
  parameter int TAG_BITS = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_req_type,
  input  wire logic [TAG_BITS-1:0] in_tag,
  input  wire logic [31:0]         in_operand_a,
  input  wire logic [31:0]         in_operand_b,
  input  wire logic                cfg_we,
  input  wire logic [5:0]          cfg_wdata,
  output logic                     out_valid,
  output logic                     out_status,
  output logic [5:0]               out_done_tag,
  output logic [31:0]              out_product,
  output logic                     out_last
);
  import fpml_pkg::*;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = TAG_BITS + 64 + 6;

  // Slot memory: tag, factors, countdown. Busy bits and done bits are flip-flops.
  logic [EW-1:0]     mem [SLOTS];
  logic [EW-1:0]     rd_data_r;
  logic [SW-1:0]     rd_addr;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;

  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [SLOTS-1:0]  done_r, done_nxt;
  logic [TAG_BITS-1:0] stag_r [SLOTS];
  logic [TAG_BITS-1:0] stag_nxt [SLOTS];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              type_r, type_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [31:0]       a_r, a_nxt, b_r, b_nxt;
  logic [5:0]        lat_r;
  logic [SW-1:0]     hit_r, hit_nxt;
  logic              hit_v_r, hit_v_nxt;
  logic [SW-1:0]     free_r, free_nxt;
  logic              free_v_r, free_v_nxt;
  logic [SW-1:0]     pick;
  logic [TAG_BITS-1:0] best;
  logic              bfound;

  // Multiply path registers.
  logic              sp_r;
  logic [47:0]       prod_r;
  logic signed [10:0] esum_r;
  logic              spec_r;
  logic [31:0]       spec_val_r;
  logic [TAG_BITS-1:0] otag_r;
  logic              olast_r;
  logic [31:0]       rnd_val;

  // Output register.
  logic              ov_r, ov_nxt, os_r, os_nxt, ol_r, ol_nxt;
  logic [5:0]        ot_r, ot_nxt;
  logic [31:0]       op_r, op_nxt;

  // Scan index from the counter.
  logic [SW-1:0]     scan_idx;
  logic [SW-1:0]     prev_idx;
  logic [5:0]        cd_dec;
  assign scan_idx = SW'(cnt_r);
  assign prev_idx = SW'(cnt_r - CW'(1));
  assign cd_dec = rd_data_r[5:0] - 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= 6'd4;
    end else if (cfg_we) begin
      lat_r <= cfg_wdata;
    end
  end

  // Memory read/write ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Pick the lowest-tag done slot; slot tags are kept in a flop copy for this.
  always_comb begin
    best = '1;
    bfound = 1'b0;
    pick = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (done_r[i] && (!bfound || stag_r[i] < best)) begin
        best = stag_r[i];
        pick = SW'(i);
        bfound = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (cnt_r == CW'(SLOTS)) begin
          if (type_r == REQ_TICK) begin
            state_nxt = (done_nxt != '0) ? ST_PICK : ST_IDLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PICK: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RND;
      ST_RND:  state_nxt = (done_r != '0) ? ST_PICK : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    type_nxt = type_r;
    tag_nxt = tag_r;
    a_nxt = a_r;
    b_nxt = b_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    hit_nxt = hit_r;
    hit_v_nxt = hit_v_r;
    free_nxt = free_r;
    free_v_nxt = free_v_r;
    for (int i = 0; i < SLOTS; i++) stag_nxt[i] = stag_r[i];
    rd_addr = scan_idx;
    wr_en = 1'b0;
    wr_addr = prev_idx;
    wr_data = rd_data_r;
    ov_nxt = 1'b0;
    os_nxt = STATUS_DONE;
    ot_nxt = '0;
    op_nxt = '0;
    ol_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          type_nxt = in_req_type;
          tag_nxt = in_tag;
          a_nxt = in_operand_a;
          b_nxt = in_operand_b;
          hit_v_nxt = 1'b0;
          free_v_nxt = 1'b0;
          done_nxt = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        // Entry cnt_r-1 read data is valid now; decrement busy slots on tick.
        if (cnt_r != '0) begin
          if (type_r == REQ_TICK) begin
            if (busy_r[prev_idx]) begin
              wr_en = 1'b1;
              wr_data = {rd_data_r[EW-1:6], cd_dec};
              if (cd_dec == 6'd0) done_nxt[prev_idx] = 1'b1;
            end
          end else begin
            if (busy_r[prev_idx] && stag_r[prev_idx] == tag_r && !hit_v_r) begin
              hit_v_nxt = 1'b1;
              hit_nxt = prev_idx;
            end
            if (!busy_r[prev_idx] && !free_v_r) begin
              free_v_nxt = 1'b1;
              free_nxt = prev_idx;
            end
          end
        end
        if (cnt_r == CW'(SLOTS) && type_r == REQ_ISSUE) begin
          if (hit_v_nxt || free_v_nxt) begin
            wr_en = 1'b1;
            wr_addr = hit_v_nxt ? hit_nxt : free_nxt;
            wr_data = {tag_r, a_r, b_r, (lat_r == 6'd0) ? 6'd1 : lat_r};
            busy_nxt[wr_addr] = 1'b1;
            stag_nxt[wr_addr] = tag_r;
          end else begin
            ov_nxt = 1'b1;
            os_nxt = STATUS_REJECT;
            ot_nxt = 6'(tag_r);
            ol_nxt = 1'b1;
          end
        end
      end
      ST_PICK: begin
        rd_addr = pick;
        done_nxt[pick] = 1'b0;
        busy_nxt[pick] = 1'b0;
      end
      ST_MUL: ;
      ST_RND: begin
        ov_nxt = 1'b1;
        os_nxt = STATUS_DONE;
        ot_nxt = 6'(otag_r);
        op_nxt = spec_r ? spec_val_r : rnd_val;
        ol_nxt = olast_r;
      end
      default: ;
    endcase
  end

  // Multiply stage: operands from the memory read of the picked slot.
  fop_t ua, ub;
  logic [31:0] fa, fb;
  assign fa = rd_data_r[69:38];
  assign fb = rd_data_r[37:6];
  always_comb begin
    ua = unpack(fa);
    ub = unpack(fb);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      sp_r <= fa[31] ^ fb[31];
      prod_r <= ua.mant * ub.mant;
      esum_r <= 11'(ua.expo) + 11'(ub.expo) - 11'sd127;
      otag_r <= rd_data_r[EW-1:70];
      olast_r <= (done_r == '0);
      spec_val_r <= {fa[31] ^ fb[31], 31'd0};
      spec_r <= 1'b0;
      if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) || (ub.is_inf && ua.is_zero))
      begin
        spec_r <= 1'b1;
        spec_val_r <= QNAN;
      end else if (ua.is_inf || ub.is_inf) begin
        spec_r <= 1'b1;
        spec_val_r <= {fa[31] ^ fb[31], 31'h7F800000};
      end else if (ua.is_zero || ub.is_zero) begin
        spec_r <= 1'b1;
      end
    end
  end

  fpml_round u_round (
    .sign(sp_r),
    .prod(prod_r),
    .expo_sum(esum_r),
    .result(rnd_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= '0;
      done_r <= '0;
      ov_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ov_r <= ov_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    tag_r <= tag_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    hit_r <= hit_nxt;
    hit_v_r <= hit_v_nxt;
    free_r <= free_nxt;
    free_v_r <= free_v_nxt;
    os_r <= os_nxt;
    ot_r <= ot_nxt;
    op_r <= op_nxt;
    ol_r <= ol_nxt;
    for (int i = 0; i < SLOTS; i++) stag_r[i] <= stag_nxt[i];
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_done_tag = ot_r;
  assign out_product = op_r;
  assign out_last = ol_r;

  // A done slot is always busy.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & ~busy_r) == '0) else $error("done slot not busy");
  // Results only come while the unit is working or just finished.
  a_out_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_RND || $past(state_r) == ST_SCAN)
    else $error("result outside sequence");
  // A new item is only taken from idle.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == ST_SCAN) else $error("start not taken");
endmodule
`default_nettype wire
